@@ sv/grtd_pkg.sv @@
// grtd_pkg: shared types and constants for the gas resistance trend detector
// depends on nothing; used by grtd_trend_core and gas_resistance_trend_detector
`timescale 1ns / 1ps

package grtd_pkg;

    // history geometry
    localparam int HISTORY_DEPTH = 16;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int ADR_X_W       = PTR_W + 1;

    // sample and arithmetic widths
    localparam int GAS_W    = 24;
    localparam int SUM_W    = GAS_W + $clog2(HISTORY_DEPTH / 2 + 1);
    localparam int DIFF_W   = SUM_W + 1;
    localparam int PROD_W   = DIFF_W + 6;
    localparam int TREND_W  = 2;

    // trend needs at least this many held samples
    localparam int MIN_FILL = 4;

    // trend codes
    localparam logic signed [TREND_W-1:0] TREND_FLAT = 2'sb00;
    localparam logic signed [TREND_W-1:0] TREND_UP   = 2'sb01;
    localparam logic signed [TREND_W-1:0] TREND_DOWN = 2'sb11;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_DRAIN,
        ST_DIFF,
        ST_MUL,
        ST_CMP,
        ST_FIN
    } t_state;

    // request from the stream side
    typedef struct packed {
        logic             start;
        logic             present;
        logic [GAS_W-1:0] sample;
    } t_req;

    // finished result handed back
    typedef struct packed {
        logic                        value_valid;
        logic [GAS_W-1:0]            gas_value;
        logic signed [TREND_W-1:0]   trend;
    } t_result;

endpackage

@@ sv/grtd_trend_core.sv @@
// grtd_trend_core: history ring, shared accumulator and trend sequencer
// depends on grtd_pkg
`timescale 1ns / 1ps

module grtd_trend_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grtd_pkg::t_req    i_req,
    output logic              o_idle,
    output logic              o_res_valid,
    output grtd_pkg::t_result o_res,
    input  logic              i_res_ack
);

    localparam int DEPTH = grtd_pkg::HISTORY_DEPTH;

    grtd_pkg::t_state r_state, n_state;

    logic [grtd_pkg::PTR_W-1:0]          r_wp;
    logic [grtd_pkg::CNT_W-1:0]          r_fill;
    logic                                r_present;
    logic [grtd_pkg::GAS_W-1:0]          r_sample;
    logic [grtd_pkg::CNT_W-1:0]          r_half;
    logic [grtd_pkg::CNT_W-1:0]          r_cnt_last;
    logic [grtd_pkg::CNT_W-1:0]          r_cnt;
    logic [grtd_pkg::PTR_W-1:0]          r_old_base;
    logic [grtd_pkg::PTR_W-1:0]          r_new_base;
    logic [grtd_pkg::GAS_W-1:0]          r_mem [DEPTH];
    logic [grtd_pkg::GAS_W-1:0]          r_rd_data;
    logic                                r_rd_vld;
    logic                                r_rd_new;
    logic [grtd_pkg::SUM_W-1:0]          r_old_sum;
    logic [grtd_pkg::SUM_W-1:0]          r_new_sum;
    logic signed [grtd_pkg::DIFF_W-1:0]  r_diff;
    logic signed [grtd_pkg::PROD_W-1:0]  r_prod;
    logic signed [grtd_pkg::TREND_W-1:0] r_trend;

    logic                                w_start;
    logic                                w_write;
    logic [grtd_pkg::CNT_W-1:0]          w_half;
    logic [grtd_pkg::PTR_W-1:0]          w_old_base;
    logic [grtd_pkg::PTR_W-1:0]          w_new_base;
    logic [grtd_pkg::CNT_W-1:0]          w_off;
    logic [grtd_pkg::PTR_W-1:0]          w_rd_addr;
    logic [grtd_pkg::SUM_W-1:0]          w_acc_in;
    logic [grtd_pkg::SUM_W-1:0]          w_acc_out;
    logic signed [grtd_pkg::PROD_W-1:0]  w_diff_x;
    logic signed [grtd_pkg::PROD_W-1:0]  w_old_x;

    // wrap a pointer sum that stays below twice the depth
    function automatic logic [grtd_pkg::PTR_W-1:0] wrap_ptr(
        input logic [grtd_pkg::ADR_X_W-1:0] x
    );
        logic [grtd_pkg::ADR_X_W-1:0] y;
        begin
            y = x;
            if (x >= grtd_pkg::ADR_X_W'(DEPTH)) begin
                y = x - grtd_pkg::ADR_X_W'(DEPTH);
            end
            return y[grtd_pkg::PTR_W-1:0];
        end
    endfunction

    assign w_start = i_req.start && (r_state == grtd_pkg::ST_IDLE);
    assign w_write = w_start && i_req.present;
    assign o_idle  = (r_state == grtd_pkg::ST_IDLE);

    // window bases from the updated pointer and fill count
    assign w_half     = r_fill >> 1;
    assign w_old_base = wrap_ptr(grtd_pkg::ADR_X_W'(r_wp) + grtd_pkg::ADR_X_W'(DEPTH)
                                 - grtd_pkg::ADR_X_W'(r_fill));
    assign w_new_base = wrap_ptr(grtd_pkg::ADR_X_W'(r_wp) + grtd_pkg::ADR_X_W'(DEPTH)
                                 - grtd_pkg::ADR_X_W'(w_half));

    // read address: old half first, then new half
    assign w_off     = (r_cnt < r_half) ? r_cnt : (r_cnt - r_half);
    assign w_rd_addr = wrap_ptr(grtd_pkg::ADR_X_W'((r_cnt < r_half) ? r_old_base : r_new_base)
                                + grtd_pkg::ADR_X_W'(w_off));

    // shared accumulator adder
    assign w_acc_in  = r_rd_new ? r_new_sum : r_old_sum;
    assign w_acc_out = w_acc_in + grtd_pkg::SUM_W'(r_rd_data);

    assign w_diff_x = grtd_pkg::PROD_W'(r_diff);
    assign w_old_x  = $signed(grtd_pkg::PROD_W'(r_old_sum));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grtd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            grtd_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.present ? grtd_pkg::ST_SETUP : grtd_pkg::ST_FIN;
                end
            end
            grtd_pkg::ST_SETUP: begin
                if (r_fill < grtd_pkg::CNT_W'(grtd_pkg::MIN_FILL)) begin
                    n_state = grtd_pkg::ST_FIN;
                end else begin
                    n_state = grtd_pkg::ST_SUM;
                end
            end
            grtd_pkg::ST_SUM: begin
                if (r_cnt == r_cnt_last) begin
                    n_state = grtd_pkg::ST_DRAIN;
                end
            end
            grtd_pkg::ST_DRAIN: n_state = grtd_pkg::ST_DIFF;
            grtd_pkg::ST_DIFF:  n_state = grtd_pkg::ST_MUL;
            grtd_pkg::ST_MUL:   n_state = grtd_pkg::ST_CMP;
            grtd_pkg::ST_CMP:   n_state = grtd_pkg::ST_FIN;
            grtd_pkg::ST_FIN: begin
                if (i_res_ack) begin
                    n_state = grtd_pkg::ST_IDLE;
                end
            end
            default: n_state = grtd_pkg::ST_IDLE;
        endcase
    end

    // ring pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (w_write) begin
            r_wp <= (r_wp == grtd_pkg::PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_fill < grtd_pkg::CNT_W'(DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // history ring, registered read
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_wp] <= i_req.sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // read tags follow the registered data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_rd_new <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == grtd_pkg::ST_SUM);
            r_rd_new <= (r_cnt >= r_half);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_present <= i_req.present;
            r_sample  <= i_req.present ? i_req.sample : '0;
            r_trend   <= grtd_pkg::TREND_FLAT;
        end
        if (r_state == grtd_pkg::ST_SETUP) begin
            r_half     <= w_half;
            r_cnt_last <= {r_fill[grtd_pkg::CNT_W-1:1], 1'b0} - 1'b1;
            r_old_base <= w_old_base;
            r_new_base <= w_new_base;
            r_cnt      <= '0;
            r_old_sum  <= '0;
            r_new_sum  <= '0;
        end
        if (r_state == grtd_pkg::ST_SUM) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_rd_vld) begin
            if (r_rd_new) begin
                r_new_sum <= w_acc_out;
            end else begin
                r_old_sum <= w_acc_out;
            end
        end
        if (r_state == grtd_pkg::ST_DIFF) begin
            r_diff <= $signed({1'b0, r_new_sum}) - $signed({1'b0, r_old_sum});
        end
        // times fifty as shifts
        if (r_state == grtd_pkg::ST_MUL) begin
            r_prod <= (w_diff_x <<< 5) + (w_diff_x <<< 4) + (w_diff_x <<< 1);
        end
        if (r_state == grtd_pkg::ST_CMP) begin
            if (r_old_sum == '0) begin
                r_trend <= grtd_pkg::TREND_FLAT;
            end else if (r_prod > w_old_x) begin
                r_trend <= grtd_pkg::TREND_UP;
            end else if (r_prod < -w_old_x) begin
                r_trend <= grtd_pkg::TREND_DOWN;
            end else begin
                r_trend <= grtd_pkg::TREND_FLAT;
            end
        end
    end

    assign o_res_valid       = (r_state == grtd_pkg::ST_FIN);
    assign o_res.value_valid = r_present;
    assign o_res.gas_value   = r_sample;
    assign o_res.trend       = r_trend;

`ifndef NO_ASSERTIONS
    // fill count never passes the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= grtd_pkg::CNT_W'(DEPTH))
        else $error("fill count beyond history depth");

    // an absent sample never reports a trend
    a_absent_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.value_valid) |-> (o_res.trend == grtd_pkg::TREND_FLAT))
        else $error("trend on absent sample");

    // history only changes on a started present sample
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != grtd_pkg::ST_IDLE) |=> $stable(r_fill) && $stable(r_wp))
        else $error("pointer moved during computation");

    // the sum walk never runs past both halves
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grtd_pkg::ST_SUM) |-> (r_cnt <= r_cnt_last) && (r_half >= 2))
        else $error("sum counter out of window");

    // a trend code is never the unused pattern
    a_trend_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.trend != 2'sb10))
        else $error("bad trend code");
`endif

endmodule

@@ sv/gas_resistance_trend_detector.sv @@
// gas_resistance_trend_detector: stream wrapper with output register around the trend core
// depends on grtd_pkg and grtd_trend_core
//
// channel  dir  handshake            tdata                         tuser
// s        in   i_s_tvalid/o_s_tready [23:0] gas_ohm               [0] sample_present
// m        out  o_m_tvalid/i_m_tready [23:0] gas_value, [25:24] trend [0] value_valid
//
// a present sample with fill n >= 4 walks the old half and then the new half through the single
// history read port feeding one adder, then steps through drain, diff, mul and cmp to the result
// absent sample: straight to the result; fewer than four held: setup, then the result
// one item at a time; the output register lets the next item start while a result waits
// synchronous active-low reset; history holds no reset pass, the fill count hides it
`timescale 1ns / 1ps

module gas_resistance_trend_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [23:0] gas_ohm
    input  logic        i_s_tuser,   // [0] sample_present
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [23:0] gas_value, [25:24] trend, [31:26] zero
    output logic        o_m_tuser    // [0] value_valid
);

    grtd_pkg::t_req    w_req;
    grtd_pkg::t_result w_res;
    grtd_pkg::t_result r_out;
    logic              w_idle;
    logic              w_res_valid;
    logic              w_ack;
    logic              r_out_vld;

    // input beat straight into the core
    assign w_req.start   = i_s_tvalid;
    assign w_req.present = i_s_tuser;
    assign w_req.sample  = i_s_tdata[grtd_pkg::GAS_W-1:0];
    assign o_s_tready    = w_idle;

    grtd_trend_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ack   (w_ack)
    );

    // take the result when the output register is free or draining
    assign w_ack = w_res_valid && (!r_out_vld || i_m_tready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ack) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'b0, r_out.trend, r_out.gas_value};
    assign o_m_tuser  = r_out.value_valid;

endmodule

@@ tb/gas_resistance_trend_detector_tb.sv @@
// gas_resistance_trend_detector_tb: self-checking stream testbench for the trend detector
// depends on grtd_pkg and gas_resistance_trend_detector; a scoreboard class predicts each beat
`timescale 1ns / 1ps

module gas_resistance_trend_detector_tb;

    localparam int N_READINGS   = 1550;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [23:0] OHM_MAX = 24'hFFFFFF;

    // expected trend results, predicted from a private copy of the history
    class trend_scoreboard;
        logic [grtd_pkg::GAS_W-1:0] ring [grtd_pkg::HISTORY_DEPTH];
        int unsigned                wr_ptr;
        int unsigned                held;
        grtd_pkg::t_result          awaited [$];
        int                         n_errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr   = 0;
            held     = 0;
            n_errors = 0;
        endfunction

        // compare mean of oldest and newest halves of the held samples
        function logic signed [grtd_pkg::TREND_W-1:0] trend_now();
            longint old_sum;
            longint new_sum;
            longint delta;
            int unsigned half;
            old_sum = 0;
            new_sum = 0;
            if (held < grtd_pkg::MIN_FILL) return grtd_pkg::TREND_FLAT;
            half = held / 2;
            for (int unsigned i = 0; i < half; i++) begin
                old_sum += ring[(wr_ptr + grtd_pkg::HISTORY_DEPTH - held + i)
                                % grtd_pkg::HISTORY_DEPTH];
                new_sum += ring[(wr_ptr + grtd_pkg::HISTORY_DEPTH - half + i)
                                % grtd_pkg::HISTORY_DEPTH];
            end
            if (old_sum == 0) return grtd_pkg::TREND_FLAT;
            delta = new_sum - old_sum;
            if (50 * delta > old_sum) return grtd_pkg::TREND_UP;
            if (50 * delta < -old_sum) return grtd_pkg::TREND_DOWN;
            return grtd_pkg::TREND_FLAT;
        endfunction

        // accepted input beat: update history and queue the expected result
        function void note_reading(logic present, logic [grtd_pkg::GAS_W-1:0] ohm);
            grtd_pkg::t_result r;
            r = '0;
            if (present) begin
                ring[wr_ptr] = ohm;
                wr_ptr = (wr_ptr + 1) % grtd_pkg::HISTORY_DEPTH;
                if (held < grtd_pkg::HISTORY_DEPTH) held++;
                r.value_valid = 1'b1;
                r.gas_value   = ohm;
                r.trend       = trend_now();
            end
            awaited.push_back(r);
        endfunction

        // accepted output beat: compare with the oldest expectation
        function void check_result(logic [31:0] tdata, logic tuser);
            grtd_pkg::t_result r;
            if (awaited.size() == 0) begin
                $error("unexpected result beat: tdata=%h tuser=%b", tdata, tuser);
                n_errors++;
                return;
            end
            r = awaited.pop_front();
            if (tuser !== r.value_valid) begin
                $error("value_valid: expected %b, got %b", r.value_valid, tuser);
                n_errors++;
            end
            if (tdata[23:0] !== r.gas_value) begin
                $error("gas_value: expected %0d, got %0d", r.gas_value, tdata[23:0]);
                n_errors++;
            end
            if (tdata[25:24] !== r.trend) begin
                $error("trend: expected %b, got %b", r.trend, tdata[25:24]);
                n_errors++;
            end
            if (tdata[31:26] !== 6'd0) begin
                $error("pad: expected 0, got %h", tdata[31:26]);
                n_errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // [23:0] gas_ohm
    logic        i_s_tuser;   // [0] sample_present
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [23:0] gas_value, [25:24] trend, [31:26] zero
    logic        o_m_tuser;   // [0] value_valid

    trend_scoreboard sb = new();
    int sent_count;
    int idle_cycles;

    gas_resistance_trend_detector u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // beat monitor and stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) sb.note_reading(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // gap before a beat; every fourth window of 200 beats runs back to back
    function automatic int pick_gap(int idx);
        if (((idx / 200) % 4) == 3) return 0;
        return $urandom_range(0, 15);
    endfunction

    // offer one reading and wait until it is taken
    task automatic push_reading(logic present, logic [23:0] ohm);
        int gap;
        gap = pick_gap(sent_count);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = present;
        i_s_tdata  = ohm;
        do @(posedge i_clk); while (!o_s_tready);
        sent_count++;
        @(negedge i_clk);
    endtask

    // directed corners: absent, short fill, zero old half, max values, rise and fall
    task automatic run_directed();
        push_reading(1'b0, OHM_MAX);
        repeat (4) push_reading(1'b1, 24'd0);
        push_reading(1'b0, 24'h5A5A5A);
        repeat (8) push_reading(1'b1, OHM_MAX);
        repeat (3) push_reading(1'b1, 24'd1);
        push_reading(1'b0, 24'd0);
        repeat (5) push_reading(1'b1, 24'd1);
    endtask

    // random episodes: drifting levels, exact 2 percent edges, noise and extremes
    task automatic run_random();
        int style;
        int run_len;
        int level;
        int span;
        int bump;
        while (sent_count < N_READINGS) begin
            style = $urandom_range(0, 9);
            if (style < 5) begin
                // slow drift around a level of random magnitude
                level = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 300)
                                                    : $urandom_range(1000, 16777215);
                run_len = $urandom_range(8, 40);
                repeat (run_len) begin
                    span = level / 25 + 1;
                    if ($urandom_range(0, 2) != 0)
                        level = level + int'($urandom_range(0, 2 * span)) - span;
                    if (level < 0) level = 0;
                    if (level > 16777215) level = 16777215;
                    push_reading($urandom_range(0, 9) != 0, level[23:0]);
                end
            end else if (style < 7) begin
                // full history whose halves differ by about the 2 percent edge
                level = $urandom_range(1, 4) * 50;
                bump  = int'($urandom_range(0, 20)) - 10;
                bump  = bump * (level / 50);
                for (int i = 0; i < grtd_pkg::HISTORY_DEPTH; i++) begin
                    if ($urandom_range(0, 7) == 0) push_reading(1'b0, 24'($urandom()));
                    push_reading(1'b1, 24'((i == grtd_pkg::HISTORY_DEPTH - 1)
                                           ? level + bump : level));
                end
            end else if (style == 7) begin
                // unrelated full-range readings
                repeat ($urandom_range(4, 20))
                    push_reading($urandom_range(0, 3) != 0, 24'($urandom()));
            end else if (style == 8) begin
                // zeros and tiny values so the old half is often empty
                repeat ($urandom_range(4, 20))
                    push_reading($urandom_range(0, 5) != 0, 24'($urandom_range(0, 3)));
            end else begin
                // readings next to the top of the range
                repeat ($urandom_range(4, 20))
                    push_reading($urandom_range(0, 5) != 0,
                                 24'(OHM_MAX - $urandom_range(0, 15)));
            end
        end
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int gap;
        int taken;
        bit held_off;
        taken    = 0;
        held_off = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = pick_gap(taken);
            if (taken == HOLD_AT && !held_off) begin
                held_off = 1'b1;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    // reset, stimulus, drain and verdict
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = 1'b0;
        i_s_tdata  = '0;
        sent_count = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        run_directed();
        run_random();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ gas_resistance_trend_detector.f @@
sv/grtd_pkg.sv
sv/grtd_trend_core.sv
sv/gas_resistance_trend_detector.sv
tb/gas_resistance_trend_detector_tb.sv
